// ===== rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Used by ffba_ctrl, ffba_dpath and first_fit_block_allocator; no dependencies.
package ffba_pkg;

    localparam int LEN_BITS  = 16;
    localparam int REQ_BITS  = 16;
    localparam int NEED_BITS = 17;
    localparam int ST_BITS   = 2;

    localparam logic [ST_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [ST_BITS-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [ST_BITS-1:0] ST_BAD_FREE = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [LEN_BITS-1:0] REGION_RESET = 16'd4096;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_CFG,
        OP_START,
        OP_SCAN,
        OP_ALLOC_PLAN,
        OP_FREE_PLAN,
        OP_SHIFT,
        OP_WR_GRANT,
        OP_WR_REMAIN,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic is_free;
        logic split;
        logic shift_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/ffba_dpath.sv =====
// Datapath of the allocator: block table memory, scan, shift engine and result register.
// Depends on ffba_pkg; driven by ffba_ctrl through ffba_pkg::dp_op_t.
module ffba_dpath #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_UNITS = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffba_pkg::dp_op_t              op,
    output ffba_pkg::dp_stat_t            stat,
    input  logic [ffba_pkg::LEN_BITS-1:0] cfg_data,
    input  logic [31:0]                   s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [15:0]                   m_tdata,
    output logic [ffba_pkg::ST_BITS-1:0]  m_tuser
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int LB = ffba_pkg::LEN_BITS;
    localparam int NB = ffba_pkg::NEED_BITS;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [NB-1:0] HDR_NEED = NB'(HEADER_UNITS);
    localparam logic [ADDR_BITS-1:0] HDR_ADDR = ADDR_BITS'(HEADER_UNITS);

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LB-1:0]        len;
        logic                 used;
    } entry_t;

    entry_t mem [MAX_BLOCKS];
    entry_t rdata_reg;
    logic            we;
    logic [IW-1:0]   waddr;
    logic [IW-1:0]   raddr;
    entry_t          wdata;

    logic [LB-1:0]        region_reg;
    logic [CW-1:0]        count_reg;
    logic                 act_reg;
    logic [NB-1:0]        need_reg;
    logic [15:0]          addr_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        chk_reg;
    logic                 chk_valid_reg;
    logic [CW-1:0]        found_idx_reg;
    entry_t               found_reg;
    entry_t               prev_reg;
    logic                 split_reg;
    logic [CW-1:0]        src_reg;
    logic [CW-1:0]        end_reg;
    logic [CW-1:0]        dst_reg;
    logic [1:0]           dist_reg;
    logic                 up_reg;
    logic                 src_act_reg;
    logic                 pipe_reg;
    logic [15:0]          res_addr_reg;
    logic [1:0]           res_st_reg;
    logic                 m_valid_reg;
    logic [15:0]          m_addr_reg;
    logic [1:0]           m_st_reg;

    logic [ADDR_BITS-1:0] rd_pay;
    logic [ADDR_BITS-1:0] found_pay;
    logic                 fit;
    logic                 own;
    logic                 hit;
    logic                 miss;
    logic [NB-1:0]        req_need;
    logic                 split_c;
    logic                 has_next;
    logic                 merge_n;
    logic                 merge_p;
    logic [LB-1:0]        merged_len;
    logic [CW-1:0]        p_idx;
    logic [ADDR_BITS-1:0] p_start;
    logic [1:0]           drop;
    logic [CW:0]          first_src;
    logic [32:0]          rem_start;

    assign rd_pay    = rdata_reg.start + HDR_ADDR;
    assign found_pay = found_reg.start + HDR_ADDR;
    assign fit  = !rdata_reg.used && ({1'b0, rdata_reg.len} >= need_reg);
    assign own  = rdata_reg.used && (32'(rd_pay) == 32'(addr_reg));
    assign hit  = chk_valid_reg && ((act_reg == ffba_pkg::ACT_ALLOC) ? fit : own);
    assign miss = chk_valid_reg && !hit && (idx_reg >= count_reg);

    always_comb begin
        req_need = NB'(s_tdata[15:0]) + HDR_NEED;
        if (req_need == '0) begin
            req_need = NB'(1);
        end
    end

    assign split_c = ({1'b0, found_reg.len} > need_reg) && (count_reg < CNT_MAX);

    // Free planning: rdata holds the entry after the found one
    assign has_next   = ((CW + 1)'(found_idx_reg) + 1'b1) < (CW + 1)'(count_reg);
    assign merge_n    = has_next && !rdata_reg.used;
    assign merge_p    = (found_idx_reg != '0) && !prev_reg.used;
    assign merged_len = found_reg.len + (merge_n ? rdata_reg.len : '0)
                        + (merge_p ? prev_reg.len : '0);
    assign p_idx      = merge_p ? found_idx_reg - CNT_ONE : found_idx_reg;
    assign p_start    = merge_p ? prev_reg.start : found_reg.start;
    assign drop       = {1'b0, merge_n} + {1'b0, merge_p};
    assign first_src  = (CW + 1)'(p_idx) + (CW + 1)'(1) + (CW + 1)'(drop);
    assign rem_start  = 33'(found_reg.start) + 33'(need_reg);

    always_comb begin
        we    = 1'b0;
        waddr = found_idx_reg[IW-1:0];
        wdata = '0;
        raddr = idx_reg[IW-1:0];
        unique case (op)
            ffba_pkg::OP_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{start: '0, len: region_reg, used: 1'b0};
            end
            ffba_pkg::OP_CFG: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{start: '0, len: cfg_data, used: 1'b0};
            end
            ffba_pkg::OP_FREE_PLAN: begin
                we    = 1'b1;
                waddr = p_idx[IW-1:0];
                wdata = '{start: p_start, len: merged_len, used: 1'b0};
            end
            ffba_pkg::OP_SHIFT: begin
                raddr = src_reg[IW-1:0];
                we    = pipe_reg;
                waddr = dst_reg[IW-1:0];
                wdata = rdata_reg;
            end
            ffba_pkg::OP_WR_GRANT: begin
                we    = 1'b1;
                wdata = '{start: found_reg.start,
                          len: split_reg ? need_reg[LB-1:0] : found_reg.len,
                          used: 1'b1};
            end
            ffba_pkg::OP_WR_REMAIN: begin
                we    = 1'b1;
                waddr = IW'(found_idx_reg + CNT_ONE);
                wdata = '{start: rem_start[ADDR_BITS-1:0],
                          len: found_reg.len - need_reg[LB-1:0],
                          used: 1'b0};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg    <= ffba_pkg::REGION_RESET;
            count_reg     <= CNT_ONE;
            chk_valid_reg <= 1'b0;
            src_act_reg   <= 1'b0;
            pipe_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // load a new transaction, or drop the one the receiver has taken
            if (op == ffba_pkg::OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (op)
                ffba_pkg::OP_INIT: begin
                    count_reg <= CNT_ONE;
                end
                ffba_pkg::OP_CFG: begin
                    region_reg <= cfg_data;
                    count_reg  <= CNT_ONE;
                end
                ffba_pkg::OP_START: begin
                    act_reg       <= s_tuser;
                    need_reg      <= req_need;
                    addr_reg      <= s_tdata[31:16];
                    idx_reg       <= '0;
                    chk_valid_reg <= 1'b0;
                end
                ffba_pkg::OP_SCAN: begin
                    idx_reg       <= idx_reg + CNT_ONE;
                    chk_reg       <= idx_reg;
                    chk_valid_reg <= 1'b1;
                    if (hit) begin
                        found_idx_reg <= chk_reg;
                        found_reg     <= rdata_reg;
                    end else if (chk_valid_reg) begin
                        prev_reg <= rdata_reg;
                    end
                    if (miss) begin
                        res_addr_reg <= '0;
                        res_st_reg   <= (act_reg == ffba_pkg::ACT_ALLOC) ?
                                        ffba_pkg::ST_NO_FIT : ffba_pkg::ST_BAD_FREE;
                    end
                end
                ffba_pkg::OP_ALLOC_PLAN: begin
                    split_reg    <= split_c;
                    res_addr_reg <= 16'(32'(found_pay));
                    res_st_reg   <= ffba_pkg::ST_OK;
                    src_reg      <= count_reg - CNT_ONE;
                    end_reg      <= found_idx_reg + CNT_ONE;
                    dist_reg     <= 2'd1;
                    up_reg       <= 1'b1;
                    src_act_reg  <= split_c && (count_reg > found_idx_reg + CNT_ONE);
                    pipe_reg     <= 1'b0;
                end
                ffba_pkg::OP_FREE_PLAN: begin
                    res_addr_reg <= '0;
                    res_st_reg   <= ffba_pkg::ST_OK;
                    src_reg      <= first_src[CW-1:0];
                    end_reg      <= count_reg - CNT_ONE;
                    dist_reg     <= drop;
                    up_reg       <= 1'b0;
                    src_act_reg  <= (drop != 2'd0) && (first_src < (CW + 1)'(count_reg));
                    pipe_reg     <= 1'b0;
                    count_reg    <= count_reg - CW'(drop);
                end
                ffba_pkg::OP_SHIFT: begin
                    pipe_reg <= src_act_reg;
                    dst_reg  <= up_reg ? src_reg + CNT_ONE : src_reg - CW'(dist_reg);
                    if (src_act_reg) begin
                        src_reg <= up_reg ? src_reg - CNT_ONE : src_reg + CNT_ONE;
                        if (src_reg == end_reg) begin
                            src_act_reg <= 1'b0;
                        end
                    end
                end
                ffba_pkg::OP_WR_REMAIN: begin
                    count_reg <= count_reg + CNT_ONE;
                end
                ffba_pkg::OP_EMIT: begin
                    m_addr_reg  <= res_addr_reg;
                    m_st_reg    <= res_st_reg;
                end
                default: begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    assign stat = '{hit: hit, miss: miss, is_free: act_reg, split: split_reg,
                    shift_busy: src_act_reg || pipe_reg,
                    out_free: !m_valid_reg || m_tready};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_st_reg;

endmodule

// ===== rtl/ffba_ctrl.sv =====
// Controller of the allocator: sequences scan, plan, shift and write steps.
// Depends on ffba_pkg; drives ffba_dpath through ffba_pkg::dp_op_t.
module ffba_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ffba_pkg::dp_stat_t stat,
    output ffba_pkg::dp_op_t   op
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_APLAN,
        S_FPLAN,
        S_SHIFT,
        S_WGRANT,
        S_WREM,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb begin
        state_next = state_reg;
        op         = ffba_pkg::OP_NONE;
        unique case (state_reg)
            S_INIT: begin
                op         = ffba_pkg::OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_valid) begin
                    op = ffba_pkg::OP_CFG;
                end else if (s_tvalid) begin
                    op         = ffba_pkg::OP_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                op = ffba_pkg::OP_SCAN;
                if (stat.hit) begin
                    state_next = stat.is_free ? S_FPLAN : S_APLAN;
                end else if (stat.miss) begin
                    state_next = S_DONE;
                end
            end
            S_APLAN: begin
                op         = ffba_pkg::OP_ALLOC_PLAN;
                state_next = S_SHIFT;
            end
            S_FPLAN: begin
                op         = ffba_pkg::OP_FREE_PLAN;
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                op = ffba_pkg::OP_SHIFT;
                if (!stat.shift_busy) begin
                    state_next = stat.is_free ? S_DONE : S_WGRANT;
                end
            end
            S_WGRANT: begin
                op         = ffba_pkg::OP_WR_GRANT;
                state_next = stat.split ? S_WREM : S_DONE;
            end
            S_WREM: begin
                op         = ffba_pkg::OP_WR_REMAIN;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the result register can take the transaction
                if (stat.out_free) begin
                    op         = ffba_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit allocator over an address-ordered block table with coalescing on free.
// Top level; instantiates ffba_ctrl and ffba_dpath, uses ffba_pkg.
//
// Usage:
//   Input channel s_*: s_tuser is the action (0 allocate, 1 free); s_tdata carries
//   request_size in bits 15:0 and block_address in bits 31:16.
//   Result channel m_*: one transaction per request; m_tdata is granted_address,
//   m_tuser is status (0 ok, 1 no fitting block, 2 bad free).
//   cfg_*: writes region_size and rebuilds the table as one free block.
// Timing: one request at a time. The scan reads one table entry per cycle from
//   the table memory, and a split or merge then moves table entries one by one;
//   the next request can be taken in the cycle after the result is loaded.
//   s_tready and cfg_ready are high only while the controller is idle.
// Reset: region_size returns to 4096 and the table to one free block; the init
//   state after reset writes table entry zero, then the block is ready.
// Stall: a result waiting on m_tready stays in its output register; the next
//   request may be taken and worked on, finishing when the register frees up.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_UNITS = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_size [15:0], block_address [31:16]
    input  logic        s_tuser,   // action [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // granted_address [15:0]
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    ffba_pkg::dp_op_t   op;
    ffba_pkg::dp_stat_t stat;

    ffba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .op        (op)
    );

    ffba_dpath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_UNITS (HEADER_UNITS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .stat     (stat),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_dual_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && cfg_valid && cfg_ready))
        else $error("request and configuration taken in one cycle");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new request taken while one is in progress");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ffba_pkg::ST_OK || m_tuser == ffba_pkg::ST_NO_FIT ||
                      m_tuser == ffba_pkg::ST_BAD_FREE))
        else $error("undefined status code");

    a_zero_addr_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ffba_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("address reported with a failed request");

endmodule
